// File: design/sbusd_pkg.sv
// ----------------------------------------------------------------------------
// sbusd_pkg
// Shared constants and controller/datapath signal groups of the serial-bus
// frame decoder.
// ----------------------------------------------------------------------------
package sbusd_pkg;

    localparam int CHANNEL_COUNT = 16;
    localparam int FRAME_BYTES   = 25;

    localparam int BYTE_W        = 8;
    localparam int CHAN_BITS     = 11;
    localparam int CHAN_IDX_W    = 4;
    localparam int POS_W         = 5;

    // byte 0 header, 1..22 packed channels, 23 flags, 24 end byte
    localparam int PACKED_BYTES  = FRAME_BYTES - 3;
    localparam int PACKED_BITS   = PACKED_BYTES * BYTE_W;
    localparam int FLAGS_POS     = FRAME_BYTES - 2;
    localparam int END_POS       = FRAME_BYTES - 1;

    localparam logic [BYTE_W-1:0] HDR_BYTE = 8'h0F;
    localparam logic [BYTE_W-1:0] END_BYTE = 8'h00;

    typedef struct packed {
        logic byte_shift;
        logic flags_load;
        logic chan_start;
        logic chan_next;
    } dp_cmd_t;

    typedef struct packed {
        logic rx_is_header;
        logic rx_is_end;
        logic chan_last;
    } dp_stat_t;

endpackage

// File: design/sbusd_if.sv
// ----------------------------------------------------------------------------
// sbusd_if
// Valid/ready channels of the frame decoder: received bytes in, channel
// results out.
// ----------------------------------------------------------------------------
interface sbusd_in_if;
    logic                           valid;
    logic                           ready;
    logic [sbusd_pkg::BYTE_W-1:0]   rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sbusd_out_if;
    logic                               valid;
    logic                               ready;
    logic [sbusd_pkg::CHAN_IDX_W-1:0]   channel_index;
    logic [sbusd_pkg::CHAN_BITS-1:0]    channel_value;
    logic [sbusd_pkg::BYTE_W-1:0]       frame_flags;
    logic                               last_of_frame;

    modport source (output valid, output channel_index, output channel_value,
                    output frame_flags, output last_of_frame, input ready);
    modport sink (input valid, input channel_index, input channel_value,
                  input frame_flags, input last_of_frame, output ready);
endinterface

// File: design/sbusd_datapath.sv
// ----------------------------------------------------------------------------
// sbusd_datapath
// Packed-byte shift register, flags register and channel counter. Bytes
// shift in little-endian; channels shift out 11 bits per result transfer.
// ----------------------------------------------------------------------------
module sbusd_datapath (
    input  logic                               clk,
    input  logic [sbusd_pkg::BYTE_W-1:0]       rx_byte,
    input  sbusd_pkg::dp_cmd_t                 cmd,
    output sbusd_pkg::dp_stat_t                status,
    output logic [sbusd_pkg::CHAN_IDX_W-1:0]   channel_index,
    output logic [sbusd_pkg::CHAN_BITS-1:0]    channel_value,
    output logic [sbusd_pkg::BYTE_W-1:0]       frame_flags,
    output logic                               last_of_frame
);
    import sbusd_pkg::*;

    logic [PACKED_BITS-1:0] packed_reg;
    logic [BYTE_W-1:0]      flags_reg;
    logic [CHAN_IDX_W-1:0]  chan_idx_reg;
    logic                   chan_last;

    always_ff @(posedge clk)
    begin
        // first byte of the frame ends up in the low bits
        if (cmd.byte_shift)
        begin
            packed_reg <= {rx_byte, packed_reg[PACKED_BITS-1:BYTE_W]};
        end
        else if (cmd.chan_next)
        begin
            packed_reg <= {{CHAN_BITS{1'b0}}, packed_reg[PACKED_BITS-1:CHAN_BITS]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.flags_load)
        begin
            flags_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.chan_start)
        begin
            chan_idx_reg <= '0;
        end
        else if (cmd.chan_next)
        begin
            chan_idx_reg <= chan_idx_reg + CHAN_IDX_W'(1);
        end
    end

    assign chan_last           = (chan_idx_reg == CHAN_IDX_W'(CHANNEL_COUNT - 1));
    assign status.rx_is_header = (rx_byte == HDR_BYTE);
    assign status.rx_is_end    = (rx_byte == END_BYTE);
    assign status.chan_last    = chan_last;

    assign channel_index = chan_idx_reg;
    assign channel_value = packed_reg[CHAN_BITS-1:0];
    assign frame_flags   = flags_reg;
    assign last_of_frame = chan_last;

endmodule

// File: design/sbusd_ctrl.sv
// ----------------------------------------------------------------------------
// sbusd_ctrl
// Frame controller: header hunt, byte position tracking, end-byte check and
// sequencing of the channel results. Holds the receive enable register.
// ----------------------------------------------------------------------------
module sbusd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  sbusd_pkg::dp_stat_t    status,
    output sbusd_pkg::dp_cmd_t     cmd
);
    import sbusd_pkg::*;

    localparam logic [1:0] ST_HUNT    = 2'd0;
    localparam logic [1:0] ST_COLLECT = 2'd1;
    localparam logic [1:0] ST_EMIT    = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             enable_reg;
    logic             take;

    assign in_ready  = (state_reg != ST_EMIT);
    assign out_valid = (state_reg == ST_EMIT);
    // with receive disabled a transfer still completes, the byte is dropped
    assign take      = in_valid && in_ready && enable_reg;

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_HUNT:
            begin
                if (take && status.rx_is_header)
                begin
                    pos_next   = POS_W'(1);
                    state_next = ST_COLLECT;
                end
            end
            ST_COLLECT:
            begin
                if (take)
                begin
                    if (pos_reg <= POS_W'(PACKED_BYTES))
                    begin
                        cmd.byte_shift = 1'b1;
                        pos_next       = pos_reg + POS_W'(1);
                    end
                    else if (pos_reg == POS_W'(FLAGS_POS))
                    begin
                        cmd.flags_load = 1'b1;
                        pos_next       = pos_reg + POS_W'(1);
                    end
                    else
                    begin
                        // end byte: a bad one drops the frame
                        pos_next = '0;
                        if (status.rx_is_end)
                        begin
                            cmd.chan_start = 1'b1;
                            state_next     = ST_EMIT;
                        end
                        else
                        begin
                            state_next = ST_HUNT;
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    cmd.chan_next = 1'b1;
                    if (status.chan_last)
                    begin
                        state_next = ST_HUNT;
                    end
                end
            end
            default:
            begin
                state_next = ST_HUNT;
                pos_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_HUNT;
            pos_reg    <= '0;
            enable_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            if (cfg_we)
            begin
                enable_reg <= cfg_wdata;
            end
        end
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(END_POS))
        else $error("byte position beyond end byte");

    a_hunt_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_COLLECT) |-> (pos_reg == '0))
        else $error("byte position not cleared outside a frame");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && status.chan_last) |=> !out_valid)
        else $error("results continue after last channel");

    a_start_emits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.chan_start |=> (out_valid && in_ready == 1'b0))
        else $error("good end byte did not start result output");

    a_disabled_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !enable_reg) |=>
            ($stable(pos_reg) && $stable(state_reg)))
        else $error("frame state moved while receive disabled");

endmodule

// File: design/sbus_frame_decoder.sv
// latency: a good end byte gives its first channel result in the next cycle
// throughput: one byte per cycle while collecting; a good frame then emits 16
//   results, one per cycle with ready high, and input is held off meanwhile
// the 176-bit packed shift register shifting one channel per transfer sets this
// reset: asynchronous, active low; hunting for header, receive enabled
// ----------------------------------------------------------------------------
// sbus_frame_decoder
// Serial-bus frame decoder: hunts for the header, collects a 25-byte frame
// and unpacks sixteen 11-bit channels with the frame flags attached.
// ----------------------------------------------------------------------------
module sbus_frame_decoder (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_wdata,
    sbusd_in_if.sink      rx,
    sbusd_out_if.source   chan
);
    import sbusd_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t status;

    sbusd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (rx.valid),
        .in_ready  (rx.ready),
        .out_valid (chan.valid),
        .out_ready (chan.ready),
        .status    (status),
        .cmd       (cmd)
    );

    sbusd_datapath u_datapath (
        .clk           (clk),
        .rx_byte       (rx.rx_byte),
        .cmd           (cmd),
        .status        (status),
        .channel_index (chan.channel_index),
        .channel_value (chan.channel_value),
        .frame_flags   (chan.frame_flags),
        .last_of_frame (chan.last_of_frame)
    );

endmodule
